// ===== src/sara_pkg.sv =====
// ----------------------------------------------------------------------------
// sara_pkg: shared types, constants and helpers
// Pool geometry, opcode and state encodings, the pool write command and the
// width conversions used between the pool and the beat fields.
// ----------------------------------------------------------------------------
`default_nettype none

package sara_pkg;

  localparam int NUM_REGS   = 4;
  localparam int TAG_BITS   = 8;
  localparam int COUNT_BITS = 8;

  localparam int IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Fixed beat field widths.
  localparam int OP_W     = 3;
  localparam int REG_W    = 4;
  localparam int OWNER_W  = 8;
  localparam int VICTIM_W = 8;

  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [TAG_BITS-1:0]   tag_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t COUNT_MAX = '1;
  localparam idx_t LAST_IDX  = IDX_BITS'(NUM_REGS - 1);
  localparam logic [REG_W:0] NUM_REGS_W = (REG_W + 1)'(NUM_REGS);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_FREE      = 3'd1,
    OP_UNSPILL   = 3'd2,
    OP_SPILL_ALL = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_COMMIT,
    ST_WALK
  } state_t;

  // One write into the pool per cycle, plus a rotating-pointer write and a whole-pool clear.
  typedef struct packed {
    logic we;
    idx_t addr;
    logic used;
    tag_t holder;
    cnt_t count;
    logic clear_all;
    logic rot_we;
    idx_t rot;
  } pool_cmd_t;

  function automatic idx_t idx_inc(input idx_t i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic tag_t tag_from_owner(input logic [OWNER_W-1:0] o);
    logic [TAG_BITS+OWNER_W-1:0] w;
    w = {{TAG_BITS{1'b0}}, o};
    return w[TAG_BITS-1:0];
  endfunction

  function automatic logic [VICTIM_W-1:0] victim_from_tag(input tag_t t);
    logic [TAG_BITS+VICTIM_W-1:0] w;
    w = {{VICTIM_W{1'b0}}, t};
    return w[VICTIM_W-1:0];
  endfunction

  function automatic logic [REG_W-1:0] reg_from_idx(input idx_t i);
    logic [IDX_BITS+REG_W-1:0] w;
    w = {{REG_W{1'b0}}, i};
    return w[REG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/sara_if.sv =====
// ----------------------------------------------------------------------------
// sara_req_if / sara_rsp_if: request and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface sara_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [3:0] reg_index;
  logic [7:0] owner_tag;

  modport source (output valid, output opcode, output reg_index, output owner_tag,
                  input ready);
  modport sink   (input valid, input opcode, input reg_index, input owner_tag,
                  output ready);
endinterface

interface sara_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] granted_reg;
  logic       spilled;
  logic [7:0] victim_tag;
  logic       status;
  logic       last;

  modport source (output valid, output granted_reg, output spilled, output victim_tag,
                  output status, output last, input ready);
  modport sink   (input valid, input granted_reg, input spilled, input victim_tag,
                  input status, input last, output ready);
endinterface

`default_nettype wire

// ===== src/sara_pool.sv =====
// ----------------------------------------------------------------------------
// sara_pool: register pool state
// Used bits, holder tags, spill counts and the rotating pointer, with one
// write and one read address per cycle and a whole-pool clear.
// ----------------------------------------------------------------------------
`default_nettype none

module sara_pool (
  input  logic                              clk,
  input  logic                              rst,
  input  sara_pkg::pool_cmd_t               cmd,
  input  sara_pkg::idx_t                    rd_addr,
  output logic [sara_pkg::NUM_REGS-1:0]     in_use,
  output sara_pkg::tag_t                    rd_holder,
  output sara_pkg::cnt_t                    rd_count,
  output sara_pkg::idx_t                    rotate_ptr
);
  import sara_pkg::*;

  tag_t holder      [NUM_REGS];
  cnt_t spill_count [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      in_use     <= '0;
      rotate_ptr <= '0;
      for (int k = 0; k < NUM_REGS; k++) begin
        holder[k]      <= '0;
        spill_count[k] <= '0;
      end
    end else begin
      if (cmd.we) begin
        in_use[cmd.addr]      <= cmd.used;
        holder[cmd.addr]      <= cmd.holder;
        spill_count[cmd.addr] <= cmd.count;
      end
      if (cmd.rot_we) begin
        rotate_ptr <= cmd.rot;
      end
    end
  end

  assign rd_holder = holder[rd_addr];
  assign rd_count  = spill_count[rd_addr];

endmodule

`default_nettype wire

// ===== src/sara_pick.sv =====
// ----------------------------------------------------------------------------
// sara_pick: victim selection scan
// Visits one pool entry per cycle from the rotating pointer with a single
// less-than compare, keeping the best free entry or, while none is free,
// the entry with the fewest spills.
// ----------------------------------------------------------------------------
`default_nettype none

module sara_pick (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  sara_pkg::idx_t                rot,
  input  logic [sara_pkg::NUM_REGS-1:0] in_use,
  input  sara_pkg::cnt_t                rd_count,
  output sara_pkg::idx_t                scan_idx,
  output logic                          done,
  output sara_pkg::idx_t                best
);
  import sara_pkg::*;

  logic busy;
  idx_t step;
  cnt_t best_cnt;
  logic found;
  logic is_free;
  logic less;

  assign is_free = !in_use[scan_idx];
  assign less    = rd_count < best_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == LAST_IDX) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // The best count starts at its maximum so that the first visit, at the
  // pointer itself, always leaves the pointer as the busy-pool fallback.
  always_ff @(posedge clk) begin
    if (start) begin
      scan_idx <= rot;
      best     <= rot;
      best_cnt <= COUNT_MAX;
      found    <= 1'b0;
      step     <= '0;
    end else if (busy) begin
      if (!found && is_free) begin
        best     <= scan_idx;
        best_cnt <= rd_count;
        found    <= 1'b1;
      end else if ((is_free || !found) && less) begin
        best     <= scan_idx;
        best_cnt <= rd_count;
      end
      scan_idx <= idx_inc(scan_idx);
      step     <= step + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/spill_aware_register_allocator.sv =====
// ----------------------------------------------------------------------------
// spill_aware_register_allocator: register pool allocator with spill tracking
// Sequencer over the pool state and the selection scan; results leave
// through an output register.
// ----------------------------------------------------------------------------
//
//   channel  direction  beat contents
//   req      in         opcode, reg_index, owner_tag
//   rsp      out        granted_reg, spilled, victim_tag, status, last
//
// One request is in work at a time; req.ready is high only while idle.
// Allocate runs decode, the selection scan over every entry, a step to see the scan
// end, then the commit, which loads the result register. Free, unspill and clear
// complete in the decode step once the output register can take their result; spill
// all then walks the entries up to the last used one. Reset is synchronous and
// clears the pool.
// A result waits in the output register while the next request is accepted;
// a further result holds its state until that register drains.
`default_nettype none

module spill_aware_register_allocator (
  input  logic       clk,
  input  logic       rst,
  sara_req_if.sink   req,
  sara_rsp_if.source rsp
);
  import sara_pkg::*;

  state_t state, state_next;

  logic [OP_W-1:0]    op_q;
  logic [REG_W-1:0]   index_q;
  logic [OWNER_W-1:0] owner_q;
  idx_t               walk, walk_next;

  pool_cmd_t          cmd;
  idx_t               rd_addr;
  logic [NUM_REGS-1:0] in_use;
  tag_t               rd_holder;
  cnt_t               rd_count;
  idx_t               rotate_ptr;

  logic pick_start;
  idx_t scan_idx;
  logic pick_done;
  idx_t best;

  logic               emit;
  logic [REG_W-1:0]   e_granted;
  logic               e_spilled;
  logic [VICTIM_W-1:0] e_victim;
  logic               e_status;
  logic               e_last;

  logic               out_valid;
  logic               can_emit;
  logic               index_ok;
  idx_t               index_a;
  logic [NUM_REGS-1:0] mask_ge, mask_gt;
  logic               used_rest, used_above;

  sara_pool u_pool (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .in_use     (in_use),
    .rd_holder  (rd_holder),
    .rd_count   (rd_count),
    .rotate_ptr (rotate_ptr)
  );

  sara_pick u_pick (
    .clk      (clk),
    .rst      (rst),
    .start    (pick_start),
    .rot      (rotate_ptr),
    .in_use   (in_use),
    .rd_count (rd_count),
    .scan_idx (scan_idx),
    .done     (pick_done),
    .best     (best)
  );

  assign req.ready = (state == ST_IDLE);
  assign can_emit  = !out_valid || rsp.ready;
  assign index_ok  = {1'b0, index_q} < NUM_REGS_W;
  assign index_a   = index_q[IDX_BITS-1:0];

  always_comb begin
    for (int k = 0; k < NUM_REGS; k++) begin
      mask_ge[k] = IDX_BITS'(k) >= walk;
      mask_gt[k] = IDX_BITS'(k) > walk;
    end
  end

  assign used_rest  = |(in_use & mask_ge);
  assign used_above = |(in_use & mask_gt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    walk <= walk_next;
    if (req.valid && req.ready) begin
      op_q    <= req.opcode;
      index_q <= req.reg_index;
      owner_q <= req.owner_tag;
    end
  end

  always_comb begin
    state_next = state;
    walk_next  = walk;
    cmd        = '0;
    rd_addr    = index_a;
    pick_start = 1'b0;
    emit       = 1'b0;
    e_granted  = '0;
    e_spilled  = 1'b0;
    e_victim   = '0;
    e_status   = 1'b0;
    e_last     = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (op_q)
          OP_ALLOC: begin
            pick_start = 1'b1;
            state_next = ST_SCAN;
          end
          OP_FREE: begin
            if (can_emit) begin
              emit       = 1'b1;
              e_granted  = index_q;
              cmd.we     = index_ok;
              cmd.addr   = index_a;
              cmd.count  = rd_count;
              state_next = ST_IDLE;
            end
          end
          OP_UNSPILL: begin
            if (can_emit) begin
              emit      = 1'b1;
              e_granted = index_q;
              if (index_ok && !in_use[index_a]) begin
                cmd.we     = 1'b1;
                cmd.addr   = index_a;
                cmd.used   = 1'b1;
                cmd.holder = tag_from_owner(owner_q);
                cmd.count  = (rd_count == '0) ? '0 : rd_count - 1'b1;
              end else begin
                e_status = 1'b1;
              end
              state_next = ST_IDLE;
            end
          end
          OP_SPILL_ALL: begin
            walk_next  = '0;
            state_next = ST_WALK;
          end
          OP_CLEAR: begin
            if (can_emit) begin
              emit          = 1'b1;
              cmd.clear_all = 1'b1;
              state_next    = ST_IDLE;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_SCAN: begin
        rd_addr = scan_idx;
        if (pick_done) begin
          state_next = ST_COMMIT;
        end
      end

      ST_COMMIT: begin
        rd_addr = best;
        if (can_emit) begin
          emit       = 1'b1;
          e_granted  = reg_from_idx(best);
          e_spilled  = in_use[best];
          e_victim   = in_use[best] ? victim_from_tag(rd_holder) : '0;
          cmd.we     = 1'b1;
          cmd.addr   = best;
          cmd.used   = 1'b1;
          cmd.holder = tag_from_owner(owner_q);
          cmd.count  = (in_use[best] && rd_count != COUNT_MAX) ? rd_count + 1'b1
                                                                : rd_count;
          cmd.rot_we = 1'b1;
          cmd.rot    = idx_inc(best);
          state_next = ST_IDLE;
        end
      end

      ST_WALK: begin
        rd_addr = walk;
        if (!used_rest) begin
          state_next = ST_IDLE;
        end else if (in_use[walk]) begin
          if (can_emit) begin
            emit      = 1'b1;
            e_granted = reg_from_idx(walk);
            e_spilled = 1'b1;
            e_victim  = victim_from_tag(rd_holder);
            e_last    = !used_above;
            cmd.we    = 1'b1;
            cmd.addr  = walk;
            cmd.count = rd_count;
            walk_next = idx_inc(walk);
          end
        end else begin
          walk_next = idx_inc(walk);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.granted_reg <= e_granted;
      rsp.spilled     <= e_spilled;
      rsp.victim_tag  <= e_victim;
      rsp.status      <= e_status;
      rsp.last        <= e_last;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// ===== src/sara_checker.sv =====
// ----------------------------------------------------------------------------
// sara_checker: port-level checks for the allocator
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module sara_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  logic [3:0] granted_reg,
  input  logic       spilled,
  input  logic [7:0] victim_tag,
  input  logic       status,
  input  logic       last
);

  // A result beat held back by the sink keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_reg) && $stable(spilled)
                                && $stable(victim_tag) && $stable(status) && $stable(last))
    else $error("result beat changed while stalled");

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another was in work");

  // Without a displaced holder there is no victim tag.
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !spilled |-> victim_tag == 8'd0)
    else $error("victim tag set on a beat that spilled nothing");

  // A failed unspill is a single beat and never reports a spill.
  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> !spilled && last)
    else $error("error status on a spill or non-final beat");

endmodule

bind spill_aware_register_allocator sara_checker u_sara_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .granted_reg (rsp.granted_reg),
  .spilled     (rsp.spilled),
  .victim_tag  (rsp.victim_tag),
  .status      (rsp.status),
  .last        (rsp.last)
);

`default_nettype wire
